[rtl/tpc_pkg.sv]
// tpc_pkg: shared widths, codes and item types of the triangle plane clipper
// depends on nothing; every other file of the block but tpc_fifo imports it
package tpc_pkg;

  localparam int COORD_W = 32;
  localparam int COL_W   = 32;
  // signed plane distance: three 64-bit products summed, minus the same again
  localparam int DIST_W  = 67;
  // magnitude of a coordinate difference, also the width of the quotient
  localparam int MAG_W   = COORD_W + 1;
  // partial remainder doubled plus one distance
  localparam int T_W     = DIST_W + 2;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_X  = 3'd0,
    CFG_POINT_Y  = 3'd1,
    CFG_POINT_Z  = 3'd2,
    CFG_NORMAL_X = 3'd3,
    CFG_NORMAL_Y = 3'd4,
    CFG_NORMAL_Z = 3'd5
  } cfg_reg_t;

  // how many vertices lie inside, in the form the back part needs
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ALL,
    KIND_ONE,
    KIND_TWO
  } kind_t;

  typedef logic [1:0] vidx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
    logic [COL_W-1:0]          colour_a;
    logic [COL_W-1:0]          colour_b;
    logic [COL_W-1:0]          colour_c;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] p_x;
    logic signed [COORD_W-1:0] p_y;
    logic signed [COORD_W-1:0] p_z;
    logic signed [COORD_W-1:0] q_x;
    logic signed [COORD_W-1:0] q_y;
    logic signed [COORD_W-1:0] q_z;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_z;
    logic [2*COL_W-1:0]        colours_front;
    logic [COL_W-1:0]          colour_back;
    logic                      last;
  } result_t;

  // classified triangle waiting for the back part
  typedef struct packed {
    vec_t [2:0]                  v;
    logic [2:0][COL_W-1:0]       col;
    logic [2:0][DIST_W-1:0]      d;
    kind_t                       kind;
    vidx_t                       s0;
    vidx_t                       e0;
    vidx_t                       s1;
    vidx_t                       e1;
  } work_t;

  // one coordinate lane of the intersection divider
  typedef struct packed {
    logic signed [COORD_W-1:0] s;
    logic                      neg;
    logic [MAG_W-1:0]          mag;
    logic [DIST_W-1:0]         rem;
    logic [MAG_W-1:0]          q;
  } lane_t;

  typedef struct packed {
    logic              slot;
    work_t             ctx;
    logic [DIST_W-1:0] den;
    logic [DIST_W-1:0] ds;
    lane_t [2:0]       ln;
  } stage_t;

endpackage

[rtl/triangle_plane_clipper.sv]
// Triangle clipper against one configurable plane. A triangle is taken on push
// when full is low and enters a two-stage front that forms the signed plane
// distances of its three vertices and classifies them; a 4-deep work queue
// follows. The back part sends every triangle twice through a shared
// three-lane intersection divider (one pass per intersection point, 33 steps,
// one quotient digit per step); a pass enters while earlier ones are still in
// it, as long as the result queue has room. Results (0, 1 or 2 triangles, the
// final one with last set) leave through a small result queue read with empty
// and pop. The user must write the plane registers through wr_en, wr_index and
// wr_data only while no triangle is in flight; the block does not enforce it.
// depends on tpc_pkg, tpc_front, tpc_fifo and tpc_back
module triangle_plane_clipper #(
  parameter int QUEUE_DEPTH = 4,
  parameter int OUT_DEPTH   = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [tpc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]                   wr_data,
  input  logic                          push,
  output logic                          full,
  input  tpc_pkg::item_t                item,
  output logic                          empty,
  input  logic                          pop,
  output tpc_pkg::result_t              result
);
  import tpc_pkg::*;

  localparam int WQ_CNT_W  = $clog2(QUEUE_DEPTH+1);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);

  logic                 take;
  logic                 wq_write;
  work_t                wq_wdata;
  logic [1:0]           inflight;
  logic                 wq_pop;
  work_t                wq_head;
  logic                 wq_empty;
  logic                 wq_full;
  logic [WQ_CNT_W-1:0]  wq_count;
  logic                 out_write;
  result_t              out_wdata;
  logic                 out_full;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 out_rd;

  // the front never stalls: it only accepts while the work queue has a place
  assign full   = (int'(wq_count) + int'(inflight)) >= QUEUE_DEPTH;
  assign take   = push && !full;
  assign out_rd = pop && !empty;

  tpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .take     (take),
    .item     (item),
    .wq_write (wq_write),
    .wq_data  (wq_wdata),
    .inflight (inflight)
  );

  tpc_fifo #(.T(work_t), .DEPTH(QUEUE_DEPTH)) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (wq_write),
    .wdata (wq_wdata),
    .rd    (wq_pop),
    .rdata (wq_head),
    .empty (wq_empty),
    .full  (wq_full),
    .count (wq_count)
  );

  tpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .wq_empty  (wq_empty),
    .wq_head   (wq_head),
    .wq_pop    (wq_pop),
    .out_full  (out_full),
    .out_write (out_write),
    .out_data  (out_wdata)
  );

  tpc_fifo #(.T(result_t), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (out_write),
    .wdata (out_wdata),
    .rd    (out_rd),
    .rdata (result),
    .empty (empty),
    .full  (out_full),
    .count (out_count)
  );

  a_credit: assert property (@(posedge clk) disable iff (rst)
      wq_write |-> (!wq_full || wq_pop))
    else $error("front wrote past its queue credit");
  a_out_count: assert property (@(posedge clk) disable iff (rst)
      out_full |-> (out_count == OUT_CNT_W'(OUT_DEPTH)))
    else $error("result queue count disagrees with full");
  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
      (wq_count == WQ_CNT_W'(QUEUE_DEPTH)) |-> !take)
    else $error("item taken with no queue space");

endmodule

[rtl/tpc_fifo.sv]
// tpc_fifo: small first-in first-out queue of any packed item type
// register storage, show-ahead read; no package dependency
module tpc_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr,
  input  T                           wdata,
  input  logic                       rd,
  output T                           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  T                 mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign empty = (count == CNT_W'(0));
  assign full  = (count == CNT_W'(DEPTH));
  assign rdata = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> (!full || rd))
    else $error("fifo written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd |-> !empty)
    else $error("fifo read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= CNT_W'(DEPTH))
    else $error("fifo count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
      (wr && !rd && !full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("fifo count out of step");

endmodule

[rtl/tpc_front.sv]
// tpc_front: plane registers, distance products and inside/outside classification
// depends on tpc_pkg; feeds the work queue of the clipper
module tpc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [tpc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]                   wr_data,
  input  logic                          take,
  input  tpc_pkg::item_t                item,
  output logic                          wq_write,
  output tpc_pkg::work_t                wq_data,
  output logic [1:0]                    inflight
);
  import tpc_pkg::*;

  logic signed [COORD_W-1:0] pt  [3];
  logic signed [COORD_W-1:0] nrm [3];

  vec_t [2:0]            vtx_in;
  logic [2:0][COL_W-1:0] col_in;

  logic                      v1;
  vec_t [2:0]                vtx1;
  logic [2:0][COL_W-1:0]     col1;
  logic signed [63:0]        prod1 [3][3];
  logic signed [63:0]        pprod1 [3];

  logic                      v2;
  vec_t [2:0]                vtx2;
  logic [2:0][COL_W-1:0]     col2;
  logic [2:0][DIST_W-1:0]    d2;

  logic signed [DIST_W-1:0]  psum;
  logic signed [DIST_W-1:0]  dsum [3];
  logic [2:0]                ins;

  // plane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pt[0]  <= '0;
      pt[1]  <= '0;
      pt[2]  <= 32'sd6554;
      nrm[0] <= '0;
      nrm[1] <= '0;
      nrm[2] <= 32'sd65536;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        CFG_POINT_X:  pt[0]  <= wr_data;
        CFG_POINT_Y:  pt[1]  <= wr_data;
        CFG_POINT_Z:  pt[2]  <= wr_data;
        CFG_NORMAL_X: nrm[0] <= wr_data;
        CFG_NORMAL_Y: nrm[1] <= wr_data;
        CFG_NORMAL_Z: nrm[2] <= wr_data;
        default: ;
      endcase
    end
  end

  // unpack the input item
  always_comb begin
    vtx_in[0] = '{x: item.a_x, y: item.a_y, z: item.a_z};
    vtx_in[1] = '{x: item.b_x, y: item.b_y, z: item.b_z};
    vtx_in[2] = '{x: item.c_x, y: item.c_y, z: item.c_z};
    col_in[0] = item.colour_a;
    col_in[1] = item.colour_b;
    col_in[2] = item.colour_c;
  end

  // stage 1: normal times vertex and normal times plane point
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take;
    end
  end

  always_ff @(posedge clk) begin
    vtx1 <= vtx_in;
    col1 <= col_in;
    for (int i = 0; i < 3; i++) begin
      prod1[i][0] <= nrm[0] * $signed(vtx_in[i].x);
      prod1[i][1] <= nrm[1] * $signed(vtx_in[i].y);
      prod1[i][2] <= nrm[2] * $signed(vtx_in[i].z);
      pprod1[i]   <= nrm[i] * pt[i];
    end
  end

  // stage 2: signed distances
  always_comb begin
    psum = DIST_W'(pprod1[0]) + DIST_W'(pprod1[1]) + DIST_W'(pprod1[2]);
    for (int i = 0; i < 3; i++) begin
      dsum[i] = DIST_W'(prod1[i][0]) + DIST_W'(prod1[i][1]) + DIST_W'(prod1[i][2]) - psum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    vtx2 <= vtx1;
    col2 <= col1;
    for (int i = 0; i < 3; i++) begin
      d2[i] <= dsum[i];
    end
  end

  // classify: a vertex is inside when its distance is not negative
  always_comb begin
    ins = {~d2[2][DIST_W-1], ~d2[1][DIST_W-1], ~d2[0][DIST_W-1]};
    wq_data      = '0;
    wq_data.v    = vtx2;
    wq_data.col  = col2;
    wq_data.d    = d2;
    unique case (ins)
      3'b000: wq_data.kind = KIND_NONE;
      3'b111: wq_data.kind = KIND_ALL;
      3'b001: begin
        wq_data.kind = KIND_ONE;
        wq_data.s0 = 2'd0; wq_data.e0 = 2'd1; wq_data.s1 = 2'd0; wq_data.e1 = 2'd2;
      end
      3'b010: begin
        wq_data.kind = KIND_ONE;
        wq_data.s0 = 2'd1; wq_data.e0 = 2'd0; wq_data.s1 = 2'd1; wq_data.e1 = 2'd2;
      end
      3'b100: begin
        wq_data.kind = KIND_ONE;
        wq_data.s0 = 2'd2; wq_data.e0 = 2'd0; wq_data.s1 = 2'd2; wq_data.e1 = 2'd1;
      end
      3'b011: begin
        wq_data.kind = KIND_TWO;
        wq_data.s0 = 2'd0; wq_data.e0 = 2'd2; wq_data.s1 = 2'd1; wq_data.e1 = 2'd2;
      end
      3'b101: begin
        wq_data.kind = KIND_TWO;
        wq_data.s0 = 2'd0; wq_data.e0 = 2'd1; wq_data.s1 = 2'd2; wq_data.e1 = 2'd1;
      end
      3'b110: begin
        wq_data.kind = KIND_TWO;
        wq_data.s0 = 2'd1; wq_data.e0 = 2'd0; wq_data.s1 = 2'd2; wq_data.e1 = 2'd0;
      end
      default: wq_data.kind = KIND_NONE;
    endcase
  end

  assign wq_write = v2;
  assign inflight = {1'b0, v1} + {1'b0, v2};

endmodule

[rtl/tpc_back.sv]
// tpc_back: intersection divider pipeline and output triangle assembly
// depends on tpc_pkg; reads the work queue, writes the result queue
module tpc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             wq_empty,
  input  tpc_pkg::work_t   wq_head,
  output logic             wq_pop,
  input  logic             out_full,
  output logic             out_write,
  output tpc_pkg::result_t out_data
);
  import tpc_pkg::*;

  localparam int NSTAGE = MAG_W;

  logic            adv;
  logic            issue;
  logic            slot;
  stage_t          st0_next;
  stage_t          st [NSTAGE+1];
  logic [NSTAGE:0] vld;
  stage_t          ex;
  logic            exv;
  vec_t            xv;
  vec_t            x0_hold;

  function automatic vec_t pick_v(vec_t [2:0] v, vidx_t i);
    vec_t r;
    unique case (i)
      2'd1:    r = v[1];
      2'd2:    r = v[2];
      default: r = v[0];
    endcase
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] pick_d(logic [2:0][DIST_W-1:0] d, vidx_t i);
    logic [DIST_W-1:0] r;
    unique case (i)
      2'd1:    r = d[1];
      2'd2:    r = d[2];
      default: r = d[0];
    endcase
    return r;
  endfunction

  function automatic lane_t mk_lane(logic signed [COORD_W-1:0] s,
                                    logic signed [COORD_W-1:0] e);
    lane_t             r;
    logic signed [MAG_W-1:0] diff;
    diff  = MAG_W'(e) - MAG_W'(s);
    r.s   = s;
    r.neg = diff[MAG_W-1];
    r.mag = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    r.rem = '0;
    r.q   = '0;
    return r;
  endfunction

  // one quotient digit (0, 1 or 2) per lane for one bit of the magnitude
  function automatic stage_t div_step(stage_t a, logic [2:0] bits);
    stage_t         r;
    logic [T_W-1:0] t;
    logic [T_W-1:0] d1;
    logic [T_W-1:0] d2;
    r  = a;
    d1 = T_W'(a.den);
    d2 = {d1[T_W-2:0], 1'b0};
    for (int l = 0; l < 3; l++) begin
      t = {1'b0, a.ln[l].rem, 1'b0} + (bits[l] ? T_W'(a.ds) : T_W'(0));
      priority if (t >= d2) begin
        r.ln[l].rem = DIST_W'(t - d2);
        r.ln[l].q   = {a.ln[l].q[MAG_W-2:0], 1'b0} + MAG_W'(2);
      end else if (t >= d1) begin
        r.ln[l].rem = DIST_W'(t - d1);
        r.ln[l].q   = {a.ln[l].q[MAG_W-2:0], 1'b1};
      end else begin
        r.ln[l].rem = DIST_W'(t);
        r.ln[l].q   = {a.ln[l].q[MAG_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] finish(lane_t ln);
    logic signed [MAG_W:0] sw;
    logic signed [MAG_W:0] qw;
    logic signed [MAG_W:0] r;
    sw = (MAG_W+1)'(ln.s);
    qw = $signed({1'b0, ln.q});
    r  = ln.neg ? sw - qw : sw + qw;
    priority if (r > (MAG_W+1)'(32'sh7FFFFFFF)) begin
      return 32'sh7FFFFFFF;
    end else if (r < (MAG_W+1)'(-33'sh80000000)) begin
      return 32'sh80000000;
    end else begin
      return COORD_W'(r);
    end
  endfunction

  function automatic result_t mk_result(vec_t p, vec_t q, vec_t r,
                                        logic [2:0][COL_W-1:0] col, logic last);
    result_t o;
    o.p_x = p.x; o.p_y = p.y; o.p_z = p.z;
    o.q_x = q.x; o.q_y = q.y; o.q_z = q.z;
    o.r_x = r.x; o.r_y = r.y; o.r_z = r.z;
    o.colours_front = {col[1], col[0]};
    o.colour_back   = col[2];
    o.last          = last;
    return o;
  endfunction

  // the whole pipeline moves only while the result queue has room
  assign adv    = !out_full;
  assign issue  = adv && !wq_empty;
  assign wq_pop = issue && slot;

  // issue: each triangle takes two slots, one per intersection point
  always_comb begin
    vidx_t sidx;
    vidx_t eidx;
    vec_t  sv;
    vec_t  ev;
    sidx = slot ? wq_head.s1 : wq_head.s0;
    eidx = slot ? wq_head.e1 : wq_head.e0;
    sv   = pick_v(wq_head.v, sidx);
    ev   = pick_v(wq_head.v, eidx);
    st0_next.slot  = slot;
    st0_next.ctx   = wq_head;
    st0_next.ds    = pick_d(wq_head.d, sidx);
    st0_next.den   = pick_d(wq_head.d, sidx) - pick_d(wq_head.d, eidx);
    st0_next.ln[0] = mk_lane(sv.x, ev.x);
    st0_next.ln[1] = mk_lane(sv.y, ev.y);
    st0_next.ln[2] = mk_lane(sv.z, ev.z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= 1'b0;
      vld  <= '0;
    end else begin
      if (issue) begin
        slot <= ~slot;
      end
      if (adv) begin
        vld <= {vld[NSTAGE-1:0], issue};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= st0_next;
    end
  end

  // divider stages, most significant magnitude bit first
  for (genvar k = 0; k < NSTAGE; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1] <= div_step(st[k], {st[k].ln[2].mag[MAG_W-1-k],
                                    st[k].ln[1].mag[MAG_W-1-k],
                                    st[k].ln[0].mag[MAG_W-1-k]});
      end
    end
  end

  assign ex  = st[NSTAGE];
  assign exv = vld[NSTAGE];

  always_comb begin
    xv.x = finish(ex.ln[0]);
    xv.y = finish(ex.ln[1]);
    xv.z = finish(ex.ln[2]);
  end

  // first intersection point waits for the second
  always_ff @(posedge clk) begin
    if (adv && exv && !ex.slot) begin
      x0_hold <= xv;
    end
  end

  // output triangles
  always_comb begin
    out_write = 1'b0;
    out_data  = mk_result(pick_v(ex.ctx.v, ex.ctx.s0), pick_v(ex.ctx.v, ex.ctx.s1), xv,
                          ex.ctx.col, 1'b0);
    if (adv && exv) begin
      if (!ex.slot) begin
        out_write = (ex.ctx.kind == KIND_TWO);
      end else begin
        unique case (ex.ctx.kind)
          KIND_ALL: begin
            out_write = 1'b1;
            out_data  = mk_result(ex.ctx.v[0], ex.ctx.v[1], ex.ctx.v[2], ex.ctx.col, 1'b1);
          end
          KIND_ONE: begin
            out_write = 1'b1;
            out_data  = mk_result(pick_v(ex.ctx.v, ex.ctx.s0), x0_hold, xv, ex.ctx.col, 1'b1);
          end
          KIND_TWO: begin
            out_write = 1'b1;
            out_data  = mk_result(pick_v(ex.ctx.v, ex.ctx.s1), x0_hold, xv, ex.ctx.col, 1'b1);
          end
          default: out_write = 1'b0;
        endcase
      end
    end
  end

  a_write_room: assert property (@(posedge clk) disable iff (rst) out_write |-> !out_full)
    else $error("result written into a full queue");
  a_slots_alternate: assert property (@(posedge clk) disable iff (rst)
      (vld[NSTAGE] && vld[NSTAGE-1]) |-> (st[NSTAGE].slot != st[NSTAGE-1].slot))
    else $error("intersection slots out of order");
  a_pop_has_work: assert property (@(posedge clk) disable iff (rst)
      wq_pop |-> (!wq_empty && slot && adv))
    else $error("work queue popped without a finished issue");

endmodule
